// ===== design/polyline_equal_spacing_resampler_top_macros.svh =====
// Assertion macros used by the resampler top-level design file.
`ifndef POLYLINE_EQUAL_SPACING_RESAMPLER_TOP_MACROS_SVH
`define POLYLINE_EQUAL_SPACING_RESAMPLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PESR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pesr assertion failed");
// Next-cycle implication, disabled during reset.
`define PESR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pesr assertion failed");
`else
`define PESR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PESR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/pesr_pkg.sv =====
// Package with shared types and constants of the polyline resampler.
`timescale 1ns / 1ps
package pesr_pkg;
    localparam int FIELD_W   = 32;
    localparam int CFG_W     = 32;
    localparam int REG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_SPACING      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_OFFSET = 2'd1;

    localparam logic [CFG_W-1:0] SPACING_RESET      = 32'd256;
    localparam logic [CFG_W-1:0] FIRST_OFFSET_RESET = 32'd128;

    // Vertex kinds.
    localparam logic OP_MOVE = 1'b0;
    localparam logic OP_LINE = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] spacing;
        logic [CFG_W-1:0] first_offset;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;
endpackage

// ===== design/pesr_in_if.sv =====
// Vertex input channel.
`timescale 1ns / 1ps
interface pesr_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic               path_start;
    logic signed [31:0] vx;
    logic signed [31:0] vy;

    modport source (output valid, op, path_start, vx, vy, input ready);
    modport sink   (input valid, op, path_start, vx, vy, output ready);
endinterface

// ===== design/pesr_out_if.sv =====
// Resampled point output channel.
`timescale 1ns / 1ps
interface pesr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               last;
    logic               overflow;

    modport source (output valid, px, py, last, overflow, input ready);
    modport sink   (input valid, px, py, last, overflow, output ready);
endinterface

// ===== design/pesr_queue.sv =====
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps
module pesr_queue #(
    parameter int W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [W-1:0]          i_data,
    input  logic                  i_pop,
    output logic [W-1:0]          o_data,
    output pesr_pkg::t_q_status   o_status
);
    import pesr_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
endmodule

// ===== design/pesr_front.sv =====
// Front part: accepts vertices, finds segment lengths and counts points.
`timescale 1ns / 1ps
module pesr_front #(
    parameter int MAX_PTS = 64,
    parameter int CW      = 32,
    parameter int CMD_W   = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pesr_in_if.sink             i_in,
    input  pesr_pkg::t_cfg      i_cfg,
    input  pesr_pkg::t_q_status i_q_status,
    output logic                o_push,
    output logic [CMD_W-1:0]    o_cmd
);
    import pesr_pkg::*;

    localparam int LW    = CW + 1;
    localparam int RW    = ((LW > CFG_W) ? LW : CFG_W) + 1;
    localparam int SW    = 2 * LW;
    localparam int CNT_W = $clog2(MAX_PTS + 1);
    localparam int STW   = $clog2(LW);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQR   = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_ROOT  = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_COUNT = 3'd5;
    localparam logic [2:0] ST_PUSH  = 3'd6;

    typedef struct packed {
        logic [CW-1:0]    prev_x;
        logic [CW-1:0]    prev_y;
        logic [CW-1:0]    nx;
        logic [CW-1:0]    ny;
        logic [LW-1:0]    len;
        logic [RW-1:0]    run0;
        logic [CFG_W-1:0] tgt0;
        logic [CFG_W-1:0] spacing;
        logic [CNT_W-1:0] n;
        logic             cut;
    } t_cmd;

    logic [2:0]       r_state;
    logic [CW-1:0]    r_prev_x, r_prev_y, r_nx, r_ny;
    logic             r_await;
    logic [RW-1:0]    r_run, r_run0;
    logic [CFG_W-1:0] r_tgt, r_tgt0;
    logic [SW-1:0]    r_ax, r_ay, r_accx, r_accy, r_rad;
    logic [LW-1:0]    r_mx, r_my, r_root;
    logic [LW+1:0]    r_rem;
    logic [STW-1:0]   r_cnt;
    logic [CNT_W-1:0] r_n;
    logic             r_cut;

    logic             accept;
    logic [CW-1:0]    in_x, in_y;
    logic [RW-1:0]    run_a;
    logic [CFG_W-1:0] tgt_a;
    logic             await_a;
    logic signed [LW-1:0] dx, dy;
    logic [LW-1:0]    absx, absy;
    logic [LW+3:0]    rt_t, rt_trial;
    logic             rt_ge;
    logic             more;
    t_cmd             cmd;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign in_x       = CW'($unsigned(i_in.vx));
    assign in_y       = CW'($unsigned(i_in.vy));

    // Path start takes effect before the vertex is used.
    always_comb begin
        run_a   = i_in.path_start ? '0 : r_run;
        tgt_a   = i_in.path_start ? i_cfg.first_offset : r_tgt;
        await_a = i_in.path_start | r_await;
        dx      = LW'(signed'(in_x)) - LW'(signed'(r_prev_x));
        dy      = LW'(signed'(in_y)) - LW'(signed'(r_prev_y));
        absx    = dx[LW-1] ? LW'(-dx) : LW'(dx);
        absy    = dy[LW-1] ? LW'(-dy) : LW'(dy);
    end

    // One root bit per step of the digit recurrence.
    always_comb begin
        rt_t     = {r_rem, r_rad[SW-1 -: 2]};
        rt_trial = {2'b00, r_root, 2'b01};
        rt_ge    = (rt_t >= rt_trial);
    end

    assign more = ({1'b0, r_run} > (RW + 1)'(r_tgt)) && (r_n < CNT_W'(MAX_PTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_await  <= 1'b1;
            r_run    <= '0;
            r_tgt    <= FIRST_OFFSET_RESET;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_run   <= run_a;
                        r_tgt   <= tgt_a;
                        r_await <= 1'b0;
                        r_nx    <= in_x;
                        r_ny    <= in_y;
                        if (await_a || i_in.op == OP_MOVE) begin
                            r_prev_x <= in_x;
                            r_prev_y <= in_y;
                        end else begin
                            r_ax    <= SW'(absx);
                            r_ay    <= SW'(absy);
                            r_mx    <= absx;
                            r_my    <= absy;
                            r_accx  <= '0;
                            r_accy  <= '0;
                            r_cnt   <= '0;
                            r_state <= ST_SQR;
                        end
                    end
                end
                // Shift-add squaring of both deltas.
                ST_SQR: begin
                    if (r_mx[0]) r_accx <= r_accx + r_ax;
                    if (r_my[0]) r_accy <= r_accy + r_ay;
                    r_ax  <= r_ax << 1;
                    r_ay  <= r_ay << 1;
                    r_mx  <= r_mx >> 1;
                    r_my  <= r_my >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == STW'(LW - 1)) r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_rad   <= r_accx + r_accy;
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= rt_ge ? (LW + 2)'(rt_t - rt_trial) : (LW + 2)'(rt_t);
                    r_root <= {r_root[LW-2:0], rt_ge};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == STW'(LW - 1)) r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_run   <= r_run + RW'(r_root);
                    r_run0  <= r_run + RW'(r_root);
                    r_tgt0  <= r_tgt;
                    r_n     <= '0;
                    r_state <= ST_COUNT;
                end
                // Step through targets to find the point count of this segment.
                ST_COUNT: begin
                    if (more) begin
                        r_run <= r_run - RW'(r_tgt);
                        r_tgt <= i_cfg.spacing;
                        r_n   <= r_n + 1'b1;
                    end else begin
                        r_cut <= (r_run > RW'(r_tgt));
                        if (r_run > RW'(r_tgt)) r_run <= '0;
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (r_n == '0 || !i_q_status.full) begin
                        r_prev_x <= r_nx;
                        r_prev_y <= r_ny;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Command beat for the back part.
    always_comb begin
        cmd.prev_x  = r_prev_x;
        cmd.prev_y  = r_prev_y;
        cmd.nx      = r_nx;
        cmd.ny      = r_ny;
        cmd.len     = r_root;
        cmd.run0    = r_run0;
        cmd.tgt0    = r_tgt0;
        cmd.spacing = i_cfg.spacing;
        cmd.n       = r_n;
        cmd.cut     = r_cut;
    end

    assign o_cmd  = cmd;
    assign o_push = (r_state == ST_PUSH) && (r_n != '0) && !i_q_status.full;
endmodule

// ===== design/pesr_back.sv =====
// Back part: interpolates each point of a segment and drives the output.
`timescale 1ns / 1ps
module pesr_back #(
    parameter int MAX_PTS = 64,
    parameter int CW      = 32,
    parameter int CMD_W   = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pesr_pkg::t_q_status i_q_status,
    input  logic [CMD_W-1:0]    i_cmd,
    output logic                o_pop,
    output logic                o_busy,
    pesr_out_if.source          o_out
);
    import pesr_pkg::*;

    localparam int LW    = CW + 1;
    localparam int QW    = LW;
    localparam int RW    = ((LW > CFG_W) ? LW : CFG_W) + 1;
    localparam int NW    = 2 * LW + 1;
    localparam int CNT_W = $clog2(MAX_PTS + 1);
    localparam int STW   = $clog2(LW);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_WGT  = 3'd1;
    localparam logic [2:0] B_MUL  = 3'd2;
    localparam logic [2:0] B_RND  = 3'd3;
    localparam logic [2:0] B_DIV  = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;

    typedef struct packed {
        logic [CW-1:0]    prev_x;
        logic [CW-1:0]    prev_y;
        logic [CW-1:0]    nx;
        logic [CW-1:0]    ny;
        logic [LW-1:0]    len;
        logic [RW-1:0]    run0;
        logic [CFG_W-1:0] tgt0;
        logic [CFG_W-1:0] spacing;
        logic [CNT_W-1:0] n;
        logic             cut;
    } t_cmd;

    t_cmd             in_cmd, r_cmd;
    logic [2:0]       r_state;
    logic [RW-1:0]    r_run;
    logic [CFG_W-1:0] r_tgt;
    logic [CNT_W-1:0] r_k;
    logic [LW-1:0]    r_absx, r_absy;
    logic             r_negx, r_negy;
    logic [NW-1:0]    r_mcx, r_mcy, r_accx, r_accy;
    logic [LW-1:0]    r_mpw;
    logic [STW-1:0]   r_cnt;
    logic [LW-1:0]    r_remx, r_remy;
    logic [QW-1:0]    r_shx, r_shy, r_qx, r_qy;
    logic             r_ovalid, r_last, r_ovf;
    logic signed [31:0] r_px, r_py;

    logic signed [LW-1:0] dx, dy;
    logic [RW-1:0]    excess;
    logic [NW-1:0]    numx, numy;
    logic [LW:0]      dvx, dvy;
    logic             gex, gey;
    logic signed [CW+1:0] fromx, fromy, resx, resy;
    logic             out_free;
    logic             is_last;

    assign in_cmd = i_cmd;

    always_comb begin
        dx     = LW'(signed'(in_cmd.nx)) - LW'(signed'(in_cmd.prev_x));
        dy     = LW'(signed'(in_cmd.ny)) - LW'(signed'(in_cmd.prev_y));
        excess = r_run - RW'(r_tgt);
        numx   = r_accx + NW'(r_cmd.len >> 1);
        numy   = r_accy + NW'(r_cmd.len >> 1);
        dvx    = {r_remx, r_shx[QW-1]};
        dvy    = {r_remy, r_shy[QW-1]};
        gex    = (dvx >= {1'b0, r_cmd.len});
        gey    = (dvy >= {1'b0, r_cmd.len});
        fromx  = (CW + 2)'(signed'(r_cmd.prev_x));
        fromy  = (CW + 2)'(signed'(r_cmd.prev_y));
        resx   = r_negx ? fromx - (CW + 2)'(r_qx) : fromx + (CW + 2)'(r_qx);
        resy   = r_negy ? fromy - (CW + 2)'(r_qy) : fromy + (CW + 2)'(r_qy);
    end

    assign out_free = !r_ovalid || o_out.ready;
    assign is_last  = (r_k == CNT_W'(r_cmd.n - 1'b1));
    assign o_pop    = (r_state == B_IDLE) && !i_q_status.empty;
    assign o_busy   = (r_state != B_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // The output register holds until taken and loads when a point is done.
            r_ovalid <= (r_ovalid && !o_out.ready) || ((r_state == B_OUT) && out_free);
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_cmd   <= in_cmd;
                        r_run   <= in_cmd.run0;
                        r_tgt   <= in_cmd.tgt0;
                        r_k     <= '0;
                        r_negx  <= dx[LW-1];
                        r_negy  <= dy[LW-1];
                        r_absx  <= dx[LW-1] ? LW'(-dx) : LW'(dx);
                        r_absy  <= dy[LW-1] ? LW'(-dy) : LW'(dy);
                        r_state <= B_WGT;
                    end
                end
                // Weight of the point; an excess past the length gives zero.
                B_WGT: begin
                    r_mpw   <= (excess > RW'(r_cmd.len)) ? '0
                                                         : LW'(r_cmd.len - excess[LW-1:0]);
                    r_mcx   <= NW'(r_absx);
                    r_mcy   <= NW'(r_absy);
                    r_accx  <= '0;
                    r_accy  <= '0;
                    r_cnt   <= '0;
                    r_state <= B_MUL;
                end
                // Shift-add products of both deltas by the weight.
                B_MUL: begin
                    if (r_mpw[0]) begin
                        r_accx <= r_accx + r_mcx;
                        r_accy <= r_accy + r_mcy;
                    end
                    r_mcx   <= r_mcx << 1;
                    r_mcy   <= r_mcy << 1;
                    r_mpw   <= r_mpw >> 1;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == STW'(LW - 1)) r_state <= B_RND;
                end
                // Add half the length for rounding and set up the division.
                B_RND: begin
                    r_remx  <= LW'(numx[NW-1:QW]);
                    r_remy  <= LW'(numy[NW-1:QW]);
                    r_shx   <= numx[QW-1:0];
                    r_shy   <= numy[QW-1:0];
                    r_cnt   <= '0;
                    r_state <= B_DIV;
                end
                // Restoring division, one quotient bit per cycle.
                B_DIV: begin
                    r_remx  <= gex ? LW'(dvx - {1'b0, r_cmd.len}) : LW'(dvx);
                    r_remy  <= gey ? LW'(dvy - {1'b0, r_cmd.len}) : LW'(dvy);
                    r_qx    <= {r_qx[QW-2:0], gex};
                    r_qy    <= {r_qy[QW-2:0], gey};
                    r_shx   <= r_shx << 1;
                    r_shy   <= r_shy << 1;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == STW'(QW - 1)) r_state <= B_OUT;
                end
                B_OUT: begin
                    if (out_free) begin
                        r_px     <= 32'(resx);
                        r_py     <= 32'(resy);
                        r_last   <= is_last;
                        r_ovf    <= r_cmd.cut;
                        r_run    <= r_run - RW'(r_tgt);
                        r_tgt    <= r_cmd.spacing;
                        r_k      <= r_k + 1'b1;
                        r_state  <= is_last ? B_IDLE : B_WGT;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.px       = r_px;
    assign o_out.py       = r_py;
    assign o_out.last     = r_last;
    assign o_out.overflow = r_ovf;
endmodule

// ===== design/polyline_equal_spacing_resampler_top.sv =====
// A line-to vertex passes through the front (squares, root, point count n), then each
// of its points through the back. One vertex per front pass; points come one per back
// pass, set by the shift-add multiplier and the restoring divider. A full queue holds
// the front and an unready output holds the back. Move-to vertices only set position.
// Reset (synchronous, active low) clears the queue and the output register, loads
// spacing 256 and first offset 128, and arms the first vertex of a path.
`timescale 1ns / 1ps
`include "polyline_equal_spacing_resampler_top_macros.svh"
module polyline_equal_spacing_resampler_top #(
    parameter int MAX_POINTS_PER_SEGMENT = 64,
    parameter int COORD_WIDTH            = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pesr_in_if.sink                         i_in,
    pesr_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [pesr_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pesr_pkg::CFG_W-1:0]      i_cfg_data
);
    import pesr_pkg::*;

    localparam int LW    = COORD_WIDTH + 1;
    localparam int RW    = ((LW > CFG_W) ? LW : CFG_W) + 1;
    localparam int CNT_W = $clog2(MAX_POINTS_PER_SEGMENT + 1);
    localparam int CMD_W = 4 * COORD_WIDTH + LW + RW + 2 * CFG_W + CNT_W + 1;

    t_cfg             r_cfg;
    t_q_status        q_status;
    logic             q_push, q_pop, back_busy;
    logic [CMD_W-1:0] push_cmd, pop_cmd;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spacing      <= SPACING_RESET;
            r_cfg.first_offset <= FIRST_OFFSET_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SPACING:      r_cfg.spacing      <= i_cfg_data;
                REG_FIRST_OFFSET: r_cfg.first_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pesr_front #(
        .MAX_PTS (MAX_POINTS_PER_SEGMENT),
        .CW      (COORD_WIDTH),
        .CMD_W   (CMD_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    pesr_queue #(
        .W (CMD_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (push_cmd),
        .i_pop    (q_pop),
        .o_data   (pop_cmd),
        .o_status (q_status)
    );

    pesr_back #(
        .MAX_PTS (MAX_POINTS_PER_SEGMENT),
        .CW      (COORD_WIDTH),
        .CMD_W   (CMD_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_cmd      (pop_cmd),
        .o_pop      (q_pop),
        .o_busy     (back_busy),
        .o_out      (o_out)
    );

    // The front never writes a full queue and the back never reads an empty one.
    `PESR_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, q_push, !q_status.full)
    `PESR_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, q_pop, !q_status.empty)
    // A popped command keeps the back part working.
    `PESR_ASSERT_NEXT(a_pop_busy, i_clk, i_rst_n, q_pop, back_busy)
endmodule

// ===== sim/polyline_equal_spacing_resampler_top_tb.sv =====
// Self-checking testbench of the equal-spacing polyline resampler.
`timescale 1ns / 1ps
module polyline_equal_spacing_resampler_top_tb;
    import pesr_pkg::*;

    localparam int MAX_PTS     = 64;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int SETTLE      = 400;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic        last;
        logic        overflow;
    } t_point;

    typedef struct {
        logic        op;
        logic        path_start;
        logic [31:0] vx;
        logic [31:0] vy;
        logic        typed;
        t_point      pt;
    } t_vertex_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [REG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    pesr_in_if  vin();
    pesr_out_if vout();

    polyline_equal_spacing_resampler_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (vin),
        .o_out      (vout),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predicted state of the block.
    logic [63:0] m_prev_x, m_prev_y, m_run_dist, m_target;
    logic        m_awaiting;
    logic [31:0] m_spacing, m_first_off;

    t_point expected_points[$];
    int     mismatches;
    int     points_seen;
    int     vertices_sent;
    int     tx_idle_pct;
    int     rx_idle_pct;
    int     cycles;

    // Clock, period 20 ns.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Run time guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d points outstanding", $time, expected_points.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [63:0] seg_length(input logic [63:0] ax, input logic [63:0] ay);
        logic [127:0] sq;
        logic [127:0] cand;
        logic [63:0]  root;
        root = 64'd0;
        sq = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
        for (int b = 56; b >= 0; b--) begin
            cand = {64'd0, root | (64'd1 << b)};
            if (cand * cand <= sq) root = root | (64'd1 << b);
        end
        return root;
    endfunction

    function automatic logic [63:0] magnitude(input logic [63:0] d);
        return d[63] ? -d : d;
    endfunction

    // Point on one axis at weight w of len, rounded half away from zero.
    function automatic logic [31:0] lerp_axis(input logic [63:0] from, input logic [63:0] to,
                                              input logic [63:0] w, input logic [63:0] len);
        logic [63:0]  d;
        logic [127:0] q;
        d = to - from;
        if (len == 64'd0) return to[31:0];
        q = ({64'd0, magnitude(d)} * {64'd0, w} + {64'd0, len >> 1}) / {64'd0, len};
        return d[63] ? 32'(from - q[63:0]) : 32'(from + q[63:0]);
    endfunction

    // Advances the predicted state by one vertex and returns the points it yields.
    task automatic resample_vertex(input logic op, input logic ps, input logic [31:0] x,
                                   input logic [31:0] y, output t_point pts[$]);
        logic [63:0] nx, ny, len, excess, w;
        logic        cut;
        t_point      p;
        nx = {{32{x[31]}}, x};
        ny = {{32{y[31]}}, y};
        pts = {};
        if (ps) begin
            m_run_dist = 64'd0;
            m_target   = {32'd0, m_first_off};
            m_awaiting = 1'b1;
        end
        if (m_awaiting || op == OP_MOVE) begin
            m_awaiting = 1'b0;
        end else begin
            len = seg_length(magnitude(nx - m_prev_x), magnitude(ny - m_prev_y));
            m_run_dist = m_run_dist + len;
            while (m_run_dist > m_target && pts.size() < MAX_PTS) begin
                excess = m_run_dist - m_target;
                w = (excess > len) ? 64'd0 : len - excess;
                p.px = lerp_axis(m_prev_x, nx, w, len);
                p.py = lerp_axis(m_prev_y, ny, w, len);
                p.last = 1'b0;
                p.overflow = 1'b0;
                pts = {pts, p};
                m_run_dist = m_run_dist - m_target;
                m_target = {32'd0, m_spacing};
            end
            cut = m_run_dist > m_target;
            if (cut) m_run_dist = 64'd0;
            foreach (pts[k]) pts[k].overflow = cut;
            if (pts.size() > 0) pts[pts.size()-1].last = 1'b1;
        end
        m_prev_x = nx;
        m_prev_y = ny;
    endtask

    // Sends one vertex beat, with a random gap ahead of it.
    task automatic send_vertex(input t_vertex_row row);
        t_point pts[$];
        if ($urandom_range(99) < tx_idle_pct) begin
            vin.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge i_clk);
        end
        vin.valid      <= 1'b1;
        vin.op         <= row.op;
        vin.path_start <= row.path_start;
        vin.vx         <= row.vx;
        vin.vy         <= row.vy;
        @(posedge i_clk);
        while (!(vin.valid && vin.ready)) @(posedge i_clk);
        resample_vertex(row.op, row.path_start, row.vx, row.vy, pts);
        if (row.typed) begin
            expected_points = {expected_points, row.pt};
        end else begin
            foreach (pts[k]) expected_points = {expected_points, pts[k]};
        end
        vertices_sent++;
    endtask

    // Waits until the block has drained, then lets a vertex still in flight finish.
    task automatic drain();
        vin.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_SPACING) m_spacing = val;
        else if (idx == REG_FIRST_OFFSET) m_first_off = val;
        @(posedge i_clk);
    endtask

    function automatic t_vertex_row vrow(input logic op, input logic ps, input logic [31:0] x,
                                         input logic [31:0] y);
        t_vertex_row r;
        r.op = op;
        r.path_start = ps;
        r.vx = x;
        r.vy = y;
        r.typed = 1'b0;
        r.pt = '{32'd0, 32'd0, 1'b0, 1'b0};
        return r;
    endfunction

    function automatic t_vertex_row vrow_typed(input logic op, input logic ps,
                                               input logic [31:0] x, input logic [31:0] y,
                                               input logic [31:0] ex, input logic [31:0] ey);
        t_vertex_row r;
        r = vrow(op, ps, x, y);
        r.typed = 1'b1;
        r.pt = '{ex, ey, 1'b1, 1'b0};
        return r;
    endfunction

    // Output beat checker and random ready.
    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n && vout.valid && vout.ready) begin
            points_seen++;
            if (expected_points.size() == 0) begin
                $display("%0t unexpected point: x %h y %h last %b ovf %b", $time,
                         vout.px, vout.py, vout.last, vout.overflow);
                mismatches++;
            end else begin
                e = expected_points.pop_front();
                if (vout.px !== e.px || vout.py !== e.py || vout.last !== e.last ||
                    vout.overflow !== e.overflow) begin
                    $display("%0t point mismatch: expected x %h y %h last %b ovf %b,",
                             $time, e.px, e.py, e.last, e.overflow,
                             " actual x %h y %h last %b ovf %b",
                             vout.px, vout.py, vout.last, vout.overflow);
                    mismatches++;
                end
            end
        end
        vout.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Stimulus.
    initial begin
        t_vertex_row table_rows[$];
        t_vertex_row r;
        logic [31:0] base_x, base_y;
        int span;

        vin.valid <= 1'b0;
        vin.op <= OP_MOVE;
        vin.path_start <= 1'b0;
        vin.vx <= 32'd0;
        vin.vy <= 32'd0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_SPACING;
        i_cfg_data <= 32'd0;
        i_rst_n <= 1'b0;
        cycles = 0;
        mismatches = 0;
        points_seen = 0;
        vertices_sent = 0;
        tx_idle_pct = 27;
        rx_idle_pct = 74;
        m_prev_x = 64'd0;
        m_prev_y = 64'd0;
        m_run_dist = 64'd0;
        m_spacing = SPACING_RESET;
        m_first_off = FIRST_OFFSET_RESET;
        m_target = {32'd0, FIRST_OFFSET_RESET};
        m_awaiting = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: a line-to right after reset only positions.
        table_rows.push_back(vrow(OP_LINE, 1'b0, 32'd0, 32'd0));
        table_rows.push_back(vrow_typed(OP_LINE, 1'b0, 32'd256, 32'd0, 32'd128, 32'd0));
        // A zero-length segment adds nothing.
        table_rows.push_back(vrow(OP_LINE, 1'b0, 32'd256, 32'd0));
        table_rows.push_back(vrow(OP_LINE, 1'b0, 32'd256, 32'd1000));
        table_rows.push_back(vrow(OP_LINE, 1'b0, -32'sd300, -32'sd77));
        table_rows.push_back(vrow(OP_MOVE, 1'b0, 32'd5, 32'd5));
        table_rows.push_back(vrow(OP_LINE, 1'b0, 32'd517, -32'sd1023));
        // Path restart on a line-to only positions.
        table_rows.push_back(vrow(OP_LINE, 1'b1, 32'd0, 32'd0));
        table_rows.push_back(vrow_typed(OP_LINE, 1'b0, 32'd0, -32'sd256, 32'd0, -32'sd128));
        table_rows.push_back(vrow(OP_LINE, 1'b0, 32'd3, 32'd3));
        // Coordinate extremes: far segments overflow the point limit.
        table_rows.push_back(vrow(OP_MOVE, 1'b1, 32'h7fffffff, 32'h80000000));
        table_rows.push_back(vrow(OP_LINE, 1'b0, 32'h80000000, 32'h7fffffff));
        table_rows.push_back(vrow(OP_LINE, 1'b0, 32'h7fffffff, 32'h7fffffff));
        table_rows.push_back(vrow(OP_LINE, 1'b0, 32'h7ffffeff, 32'h7fffff80));
        foreach (table_rows[i]) send_vertex(table_rows[i]);
        drain();

        // Extreme register settings, a short walk under each.
        write_reg(REG_SPACING, 32'd1);
        write_reg(REG_FIRST_OFFSET, 32'd0);
        send_vertex(vrow(OP_MOVE, 1'b1, 32'd0, 32'd0));
        send_vertex(vrow(OP_LINE, 1'b0, 32'd20, -32'sd15));
        send_vertex(vrow(OP_LINE, 1'b0, 32'd40, 32'd0));
        drain();
        write_reg(REG_SPACING, 32'hffffffff);
        write_reg(REG_FIRST_OFFSET, 32'hffffffff);
        send_vertex(vrow(OP_MOVE, 1'b1, 32'h80000000, 32'h80000000));
        send_vertex(vrow(OP_LINE, 1'b0, 32'h7fffffff, 32'h7fffffff));
        send_vertex(vrow(OP_LINE, 1'b0, 32'h80000000, 32'h80000000));
        drain();
        // A spacing of zero saturates every segment with length.
        write_reg(REG_SPACING, 32'd0);
        write_reg(REG_FIRST_OFFSET, 32'd10);
        send_vertex(vrow(OP_MOVE, 1'b1, 32'd100, 32'd100));
        send_vertex(vrow(OP_LINE, 1'b0, 32'd130, 32'd60));
        drain();

        // Random part: three idle profiles, new registers for each.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 74 : 0;
            rx_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 27 : 0;
            write_reg(REG_SPACING, $urandom_range(2048, 64));
            write_reg(REG_FIRST_OFFSET, $urandom_range(m_spacing, 0));
            base_x = $urandom();
            base_y = $urandom();
            for (int n = 0; n < 134; n++) begin
                if (n == 60) drain();
                span = ($urandom_range(9) == 0) ? 16384 : 1024;
                case ($urandom_range(19))
                    0: r = vrow(OP_MOVE, 1'($urandom_range(1)), $urandom(), $urandom());
                    1: r = vrow(OP_LINE, 1'($urandom_range(1)), $urandom(), $urandom());
                    2: r = vrow(OP_MOVE, 1'b1, base_x, base_y);
                    3: r = vrow(OP_LINE, 1'b0, base_x, base_y);
                    default: begin
                        base_x = base_x + $urandom_range(2 * span) - span;
                        base_y = base_y + $urandom_range(2 * span) - span;
                        r = vrow(OP_LINE, ($urandom_range(29) == 0), base_x, base_y);
                    end
                endcase
                if (r.op == OP_MOVE || r.path_start) begin
                    base_x = r.vx;
                    base_y = r.vy;
                end
                send_vertex(r);
            end
            drain();
        end

        $display("Covered %0d vertices and %0d output points under three idle profiles,",
                 vertices_sent, points_seen);
        $display("with spacing and first offset swept from zero to full scale.");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
